// File: sv/rsame_pkg.sv
// ----------------------------------------------------------------------------
// rsame_pkg
// shared constants and controller/datapath types for the modular
// exponentiation block
// ----------------------------------------------------------------------------
package rsame_pkg;

   localparam int MOD_BITS_DEFAULT = 36;
   localparam int CSR_IDX_BITS     = 8;

   // register indexes on the configuration port
   localparam logic [CSR_IDX_BITS-1:0] REG_MODULUS  = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_EXPONENT = 8'd1;

   // register reset values, truncated to the datapath width where used
   localparam logic [63:0] MODULUS_RESET  = 64'd10547596117;  // 101467 * 103951
   localparam logic [63:0] EXPONENT_RESET = 64'd14293;

   // operand selection for the shared modular multiplier
   typedef enum logic [1:0] {
      MM_REDUCE = 2'd0,   // 1 * base, reduces the base mod n
      MM_MUL    = 2'd1,   // result * square
      MM_SQR    = 2'd2    // square * square
   } mm_sel_type;

   typedef struct packed {
      logic       start;      // load multiplier operands, clear accumulator
      mm_sel_type sel;        // operand choice for start
      logic       step;       // one multiplier bit
      logic       store_sq;   // capture multiplier result as the square
      logic       store_res;  // capture multiplier result as the power
      logic       shift_ex;   // drop the exponent lsb
      logic       load_out;   // move the power into the output register
   } dp_cmd_type;

   typedef struct packed {
      logic mod_small;    // modulus below two
      logic ex_zero;      // no exponent bits left
      logic ex_lsb;       // current exponent bit
      logic ex_rest_zero; // no set bits above the current one
      logic out_free;     // output register can take a result this cycle
   } dp_status_type;

endpackage

// File: sv/rsame_if.sv
// ----------------------------------------------------------------------------
// rsame interfaces
// valid/ready channels for the message, the result and register writes
// ----------------------------------------------------------------------------
interface rsame_req_if #(parameter int W = rsame_pkg::MOD_BITS_DEFAULT);
   logic         valid;
   logic         ready;
   logic [W-1:0] base_value;

   modport source (output valid, output base_value, input ready);
   modport sink   (input valid, input base_value, output ready);
endinterface

interface rsame_rsp_if #(parameter int W = rsame_pkg::MOD_BITS_DEFAULT);
   logic         valid;
   logic         ready;
   logic [W-1:0] power_result;

   modport source (output valid, output power_result, input ready);
   modport sink   (input valid, input power_result, output ready);
endinterface

interface rsame_csr_if #(parameter int W = rsame_pkg::MOD_BITS_DEFAULT);
   logic                               valid;
   logic                               ready;
   logic [rsame_pkg::CSR_IDX_BITS-1:0] index;
   logic [W-1:0]                       wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: sv/rsame_ctrl.sv
// ----------------------------------------------------------------------------
// rsame_ctrl
// sequencer for reduce, multiply and square passes of the shared multiplier
// ----------------------------------------------------------------------------
module rsame_ctrl #(
   parameter int MOD_BITS = rsame_pkg::MOD_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rsame_pkg::dp_status_type status,
   output rsame_pkg::dp_cmd_type    cmd
);
   import rsame_pkg::*;

   localparam int CNT_BITS = $clog2(MOD_BITS);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_REDUCE = 6'b000010,
      ST_CHECK  = 6'b000100,
      ST_MULT   = 6'b001000,
      ST_SQUARE = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                cnt_last;

   assign cnt_last  = (cnt_ff == CNT_BITS'(MOD_BITS - 1));
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      cmd.sel  = MM_REDUCE;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               cmd.sel   = MM_REDUCE;
               cnt_in    = '0;
               state_in  = status.mod_small ? ST_FINISH : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_last) begin
               cmd.store_sq = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cnt_in = '0;
            if (status.ex_zero) begin
               state_in = ST_FINISH;
            end else if (status.ex_lsb) begin
               cmd.start = 1'b1;
               cmd.sel   = MM_MUL;
               state_in  = ST_MULT;
            end else begin
               cmd.start = 1'b1;
               cmd.sel   = MM_SQR;
               state_in  = ST_SQUARE;
            end
         end
         ST_MULT: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_last) begin
               cmd.store_res = 1'b1;
               if (status.ex_rest_zero) begin
                  // top exponent bit done, last square is not needed
                  state_in = ST_FINISH;
               end else begin
                  cmd.start = 1'b1;
                  cmd.sel   = MM_SQR;
                  cnt_in    = '0;
                  state_in  = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_last) begin
               cmd.store_sq = 1'b1;
               cmd.shift_ex = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("controller stayed idle after a transaction");

   a_pass_ends_on_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.store_sq || cmd.store_res) |-> cnt_last)
      else $error("multiplier result stored before the last bit");
`endif

endmodule

// File: sv/rsame_dp.sv
// ----------------------------------------------------------------------------
// rsame_dp
// configuration registers, bit-serial modular multiplier, exponent shifter
// and output register
// ----------------------------------------------------------------------------
module rsame_dp #(
   parameter int MOD_BITS = rsame_pkg::MOD_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [rsame_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [MOD_BITS-1:0]                csr_wdata,
   input  logic [MOD_BITS-1:0]                base_value,
   input  rsame_pkg::dp_cmd_type              cmd,
   output rsame_pkg::dp_status_type           status,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [MOD_BITS-1:0]                power_result
);
   import rsame_pkg::*;

   logic [MOD_BITS-1:0] mod_ff, exp_ff;
   logic [MOD_BITS-1:0] ex_ff, res_ff, sq_ff;
   logic [MOD_BITS-1:0] acc_ff, mul_a_ff, mul_b_ff;
   logic [MOD_BITS-1:0] out_ff;
   logic                out_valid_ff;

   logic [MOD_BITS:0]   dbl, sum;
   logic [MOD_BITS-1:0] dbl_red, sum_red, acc_in;
   logic [MOD_BITS-1:0] start_a, start_b;

   // one multiplier bit: acc = 2*acc mod n, then + a mod n if the b bit is set
   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, mod_ff}) ? MOD_BITS'(dbl - {1'b0, mod_ff})
                                        : dbl[MOD_BITS-1:0];
      sum     = {1'b0, dbl_red} + {1'b0, mul_a_ff};
      sum_red = (sum >= {1'b0, mod_ff}) ? MOD_BITS'(sum - {1'b0, mod_ff})
                                        : sum[MOD_BITS-1:0];
      acc_in  = mul_b_ff[MOD_BITS-1] ? sum_red : dbl_red;
   end

   always_comb begin
      case (cmd.sel)
         MM_MUL: begin
            start_a = res_ff;
            start_b = sq_ff;
         end
         MM_SQR: begin
            start_a = sq_ff;
            start_b = sq_ff;
         end
         default: begin
            start_a = MOD_BITS'(1);
            start_b = base_value;
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MODULUS_RESET[MOD_BITS-1:0];
         exp_ff <= EXPONENT_RESET[MOD_BITS-1:0];
      end else if (csr_write) begin
         if (csr_index == REG_MODULUS) begin
            mod_ff <= csr_wdata;
         end else if (csr_index == REG_EXPONENT) begin
            exp_ff <= csr_wdata;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_ff   <= '0;
         mul_a_ff <= start_a;
         mul_b_ff <= start_b;
      end else if (cmd.step) begin
         acc_ff   <= acc_in;
         mul_b_ff <= {mul_b_ff[MOD_BITS-2:0], 1'b0};
      end
      if (cmd.start && (cmd.sel == MM_REDUCE)) begin
         res_ff <= MOD_BITS'(1);
         ex_ff  <= exp_ff;
      end else begin
         if (cmd.store_res) begin
            res_ff <= acc_in;
         end
         if (cmd.shift_ex) begin
            ex_ff <= ex_ff >> 1;
         end
      end
      if (cmd.store_sq) begin
         sq_ff <= acc_in;
      end
      if (cmd.load_out) begin
         out_ff <= status.mod_small ? '0 : res_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign power_result = out_ff;

   always_comb begin
      status.mod_small    = (mod_ff[MOD_BITS-1:1] == '0);
      status.ex_zero      = (ex_ff == '0);
      status.ex_lsb       = ex_ff[0];
      status.ex_rest_zero = (ex_ff[MOD_BITS-1:1] == '0);
      status.out_free     = !out_valid_ff || rsp_ready;
   end

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!out_valid_ff || rsp_ready))
      else $error("result loaded over a pending transaction");

   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && !cmd.start && !status.mod_small) |=> (acc_ff < mod_ff))
      else $error("multiplier accumulator not reduced");

   a_res_reduced: assert property (@(posedge clock) disable iff (reset)
      (cmd.store_res && !status.mod_small) |=> (res_ff < mod_ff))
      else $error("stored power not reduced");
`endif

endmodule

// File: sv/rsa_modular_exponentiation_top.sv
// sequence: reduction of the base, then for each exponent bit up to the top set bit
//   a check, a multiply pass if the bit is set and a square pass unless it is the top
//   bit, then the load into the output register; a modulus below two skips straight
//   to the load
// throughput: one item at a time, set by the bit-serial modular multiplier
//   (one multiplier bit per cycle, shared by reduce, multiply and square)
// reset: synchronous active high, idle, output empty, registers at default key
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation_top
// right-to-left square-and-multiply modular exponentiation of one message
// value per transaction with a configured modulus and exponent
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation_top #(
   parameter int MOD_BITS = rsame_pkg::MOD_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   rsame_req_if.sink  req_bus,   // message values in
   rsame_rsp_if.source rsp_bus,  // powers out
   rsame_csr_if.sink  csr_bus    // modulus and exponent writes
);
   import rsame_pkg::*;

   dp_cmd_type    cmd;     // controller to datapath
   dp_status_type status;  // datapath to controller

   // register writes land at once, the port never stalls
   assign csr_bus.ready = 1'b1;

   // sequencer: reduce the base, then walk the exponent lsb first
   rsame_ctrl #(
      .MOD_BITS (MOD_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // registers, multiplier and output stage; the output register lets the
   // next transaction start while a result still waits downstream
   rsame_dp #(
      .MOD_BITS (MOD_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_bus.valid),
      .csr_index    (csr_bus.index),
      .csr_wdata    (csr_bus.wdata),
      .base_value   (req_bus.base_value),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .power_result (rsp_bus.power_result)
   );

endmodule
